// ===== rtl/core/lesf_pkg.sv =====
package lesf_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned SCORE_W = 11;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned CFG_W   = 2;

  localparam int unsigned MAX_COLS_DEF = 1024;
  localparam int unsigned MAX_ROWS_DEF = 1024;

  localparam logic [CHAR_W-1:0]  EMPTY_CHAR_RST = 8'd46;
  localparam logic [DIM_W-1:0]   MAP_DIM_RST    = 11'd1024;
  localparam logic [SCORE_W-1:0] SCORE_MAX      = 11'd2047;

  typedef enum logic [CFG_W-1:0] {
    CFG_EMPTY_CHAR = 2'd0,
    CFG_MAP_COLS   = 2'd1,
    CFG_MAP_ROWS   = 2'd2
  } cfg_idx_e;

  // Everything the score stage needs to know about one cell.
  typedef struct packed {
    logic             match;
    logic             first_row;
    logic             first_col;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } cell_t;

endpackage

// ===== rtl/core/lesf_scan.sv =====
module lesf_scan #(
  parameter int unsigned MaxCols = lesf_pkg::MAX_COLS_DEF,
  parameter int unsigned MaxRows = lesf_pkg::MAX_ROWS_DEF,
  localparam int unsigned CW = $clog2(MaxCols),
  localparam int unsigned RW = $clog2(MaxRows)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [lesf_pkg::CHAR_W-1:0] cell_char_i,
  input  logic [lesf_pkg::CHAR_W-1:0] empty_char_i,
  input  logic [lesf_pkg::DIM_W-1:0]  map_cols_i,
  input  logic [lesf_pkg::DIM_W-1:0]  map_rows_i,
  output lesf_pkg::cell_t             cell_o,
  output logic [CW-1:0]               col_o
);

  localparam int unsigned CDW = (lesf_pkg::DIM_W > CW + 1) ? lesf_pkg::DIM_W : CW + 1;
  localparam int unsigned RDW = (lesf_pkg::DIM_W > RW + 1) ? lesf_pkg::DIM_W : RW + 1;

  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [CDW-1:0] cols, col_inc;
  logic [RDW-1:0] rows, row_inc;
  logic           row_end, map_end;
  logic [CW+9:0]  col_ext;
  logic [RW+9:0]  row_ext;

  always_comb begin
    cols = CDW'(map_cols_i);
    if (cols == '0) begin
      cols = CDW'(1);
    end else if (cols > CDW'(MaxCols)) begin
      cols = CDW'(MaxCols);
    end
    rows = RDW'(map_rows_i);
    if (rows == '0) begin
      rows = RDW'(1);
    end else if (rows > RDW'(MaxRows)) begin
      rows = RDW'(MaxRows);
    end
  end

  assign col_inc = CDW'(col_q) + CDW'(1);
  assign row_inc = RDW'(row_q) + RDW'(1);
  assign row_end = (col_inc >= cols);
  assign map_end = row_end && (row_inc >= rows);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (!row_end) begin
        col_d = col_inc[CW-1:0];
      end else begin
        col_d = '0;
        row_d = map_end ? '0 : row_inc[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_ext = (CW + 10)'(col_q);
  assign row_ext = (RW + 10)'(row_q);

  assign cell_o.match     = (cell_char_i == empty_char_i);
  assign cell_o.first_row = (row_q == '0);
  assign cell_o.first_col = (col_q == '0);
  assign cell_o.last      = map_end;
  assign cell_o.row       = row_ext[lesf_pkg::POS_W-1:0];
  assign cell_o.col       = col_ext[lesf_pkg::POS_W-1:0];
  assign col_o            = col_q;

endmodule

// ===== rtl/core/lesf_line_buf.sv =====
module lesf_line_buf #(
  parameter int unsigned MaxCols = lesf_pkg::MAX_COLS_DEF,
  localparam int unsigned CW = $clog2(MaxCols)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [CW-1:0]                rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [CW-1:0]                wr_addr_i,
  input  logic [lesf_pkg::SCORE_W-1:0] wr_data_i,
  output logic [lesf_pkg::SCORE_W-1:0] up_o
);

  logic [lesf_pkg::SCORE_W-1:0] mem [MaxCols];
  logic [lesf_pkg::SCORE_W-1:0] rd_q;
  logic [lesf_pkg::SCORE_W-1:0] fwd_data_q;
  logic                         fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // A read of the entry being written in the same cycle takes the new score.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_data_i;
    end
  end

  assign up_o = fwd_q ? fwd_data_q : rd_q;

  a_fwd_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i && wr_en_i && (wr_addr_i == rd_addr_i) |=> up_o == $past(wr_data_i))
    else $error("line buffer read missed a same-cycle write");

endmodule

// ===== rtl/core/lesf_score.sv =====
module lesf_score #(
  parameter int unsigned MaxCols = lesf_pkg::MAX_COLS_DEF,
  localparam int unsigned CW = $clog2(MaxCols)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  lesf_pkg::cell_t              cell_i,
  input  logic [CW-1:0]                col_i,
  input  logic [lesf_pkg::SCORE_W-1:0] up_i,
  output logic                         advance_o,
  output logic                         wr_en_o,
  output logic [CW-1:0]                wr_addr_o,
  output logic [lesf_pkg::SCORE_W-1:0] wr_data_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lesf_pkg::SCORE_W-1:0] out_size_o,
  output logic [lesf_pkg::POS_W-1:0]   out_row_o,
  output logic [lesf_pkg::POS_W-1:0]   out_col_o
);

  localparam int unsigned SW = lesf_pkg::SCORE_W;
  localparam int unsigned PW = lesf_pkg::POS_W;

  logic            s1_valid_q;
  lesf_pkg::cell_t s1_cell_q;
  logic [CW-1:0]   s1_addr_q;
  logic [SW-1:0]   left_q, diag_q;
  logic [SW-1:0]   best_size_q, best_size_d;
  logic [PW-1:0]   best_row_q, best_row_d, best_col_q, best_col_d;
  logic            out_valid_q;
  logic [SW-1:0]   out_size_q;
  logic [PW-1:0]   out_row_q, out_col_q;

  logic [SW-1:0]   up, min_lu, min3;
  logic [SW:0]     inc;
  logic [SW-1:0]   score;
  logic            step, emit, better;

  // Only a finished map stalls, and only while the previous result is still held.
  assign advance_o = !s1_valid_q || !s1_cell_q.last || !out_valid_q || out_ready_i;
  assign step      = s1_valid_q && advance_o;
  assign emit      = step && s1_cell_q.last;

  assign up     = s1_cell_q.first_row ? '0 : up_i;
  assign min_lu = (left_q < up) ? left_q : up;
  assign min3   = (min_lu < diag_q) ? min_lu : diag_q;
  assign inc    = {1'b0, min3} + (SW + 1)'(1);

  always_comb begin
    if (!s1_cell_q.match) begin
      score = '0;
    end else if (s1_cell_q.first_row || s1_cell_q.first_col) begin
      score = SW'(1);
    end else if (inc[SW]) begin
      score = lesf_pkg::SCORE_MAX;
    end else begin
      score = inc[SW-1:0];
    end
  end

  assign better = (score > best_size_q);

  always_comb begin
    best_size_d = best_size_q;
    best_row_d  = best_row_q;
    best_col_d  = best_col_q;
    if (better) begin
      best_size_d = score;
      best_row_d  = s1_cell_q.row;
      best_col_d  = s1_cell_q.col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
    end else begin
      if (advance_o) begin
        s1_valid_q <= accept_i;
      end
      if (step) begin
        if (emit) begin
          best_size_q <= '0;
          best_row_q  <= '0;
          best_col_q  <= '0;
        end else begin
          best_size_q <= best_size_d;
          best_row_q  <= best_row_d;
          best_col_q  <= best_col_d;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_cell_q <= cell_i;
      s1_addr_q <= col_i;
    end
    if (step) begin
      left_q <= score;
      diag_q <= up;
    end
    if (emit) begin
      out_size_q <= best_size_d;
      out_row_q  <= best_row_d;
      out_col_q  <= best_col_d;
    end
  end

  assign wr_en_o     = step;
  assign wr_addr_o   = s1_addr_q;
  assign wr_data_o   = score;
  assign out_valid_o = out_valid_q;
  assign out_size_o  = out_size_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ready_i))
    else $error("result issued over an unaccepted result");

  a_best_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> best_size_q == '0)
    else $error("best square not cleared after a map");

  a_obstacle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_cell_q.match |-> score == '0)
    else $error("obstacle cell scored above zero");

  a_best_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !emit |=> best_size_q >= $past(best_size_q))
    else $error("best square shrank within a map");

endmodule

// ===== rtl/core/largest_empty_square_finder.sv =====
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] cell_char
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata square_size, corner_row, corner_col
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i register, cfg_data_i value
//
// One cell is taken per cycle unless stalled; the line buffer read is issued in the beat's
// cycle, the score is formed from the registered cell and written back when that stage
// advances, and the result is registered again before it leaves. The line buffer is not
// cleared at reset; the first row of a map never uses it. The input stalls only while a
// finished map waits behind an unaccepted result. Configuration writes are always taken.
module largest_empty_square_finder #(
  parameter int unsigned MaxCols = lesf_pkg::MAX_COLS_DEF,
  parameter int unsigned MaxRows = lesf_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] cell_char
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata,   // [10:0] square_size, [20:11] corner_row,
                                                     // [30:21] corner_col, [31] zero
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lesf_pkg::CFG_W-1:0] cfg_index_i,
  input  logic [lesf_pkg::DIM_W-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MaxCols);

  logic [lesf_pkg::CHAR_W-1:0]  empty_char_q;
  logic [lesf_pkg::DIM_W-1:0]   map_cols_q, map_rows_q;
  logic                         accept, advance;
  lesf_pkg::cell_t              cur_cell;
  logic [CW-1:0]                rd_col, wr_addr;
  logic                         wr_en;
  logic [lesf_pkg::SCORE_W-1:0] wr_data, up;
  logic [lesf_pkg::SCORE_W-1:0] out_size;
  logic [lesf_pkg::POS_W-1:0]   out_row, out_col;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_char_q <= lesf_pkg::EMPTY_CHAR_RST;
      map_cols_q   <= lesf_pkg::MAP_DIM_RST;
      map_rows_q   <= lesf_pkg::MAP_DIM_RST;
    end else if (cfg_valid_i) begin
      unique case (lesf_pkg::cfg_idx_e'(cfg_index_i))
        lesf_pkg::CFG_EMPTY_CHAR: empty_char_q <= cfg_data_i[lesf_pkg::CHAR_W-1:0];
        lesf_pkg::CFG_MAP_COLS:   map_cols_q   <= cfg_data_i;
        lesf_pkg::CFG_MAP_ROWS:   map_rows_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid && advance;

  lesf_scan #(
    .MaxCols(MaxCols),
    .MaxRows(MaxRows)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cell_char_i (s_axis_tdata),
    .empty_char_i(empty_char_q),
    .map_cols_i  (map_cols_q),
    .map_rows_i  (map_rows_q),
    .cell_o      (cur_cell),
    .col_o       (rd_col)
  );

  lesf_line_buf #(
    .MaxCols(MaxCols)
  ) u_line_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_addr_i(rd_col),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .up_o     (up)
  );

  lesf_score #(
    .MaxCols(MaxCols)
  ) u_score (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cell_i     (cur_cell),
    .col_i      (rd_col),
    .up_i       (up),
    .advance_o  (advance),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_size_o (out_size),
    .out_row_o  (out_row),
    .out_col_o  (out_col)
  );

  assign m_axis_tdata = {1'b0, out_col, out_row, out_size};

endmodule
